[src/tgbc_pkg.sv]
// Package for the tile grid box collision core: geometry constants, field widths,
// derived fixed-point constants and the action and register codes.
// No dependencies.
package tgbc_pkg;

  // Geometry, in pixels
  localparam int unsigned MAP_SIDE_MAX_DEF = 64;
  localparam int unsigned TILE_PX          = 64;
  localparam int unsigned AGENT_PX         = 60;
  localparam int unsigned AGENT_RADIUS_PX  = 30;
  localparam int unsigned FRAC_BITS        = 4;

  // Field widths
  localparam int unsigned POS_W     = 20;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAP_RESET_TILES = 64;

  // Internal widths
  localparam int unsigned IDX_W  = 9;   // any map side up to 256
  localparam int unsigned WORK_W = 24;  // signed working position
  localparam int unsigned PIX_W  = 20;  // nonnegative whole-pixel coordinate

  // Fixed-point geometry
  localparam int TILE       = int'(TILE_PX) <<< FRAC_BITS;
  localparam int HALF       = TILE >>> 1;
  localparam int RAD        = int'(AGENT_RADIUS_PX) <<< FRAC_BITS;
  localparam int SIDE       = int'(AGENT_PX) <<< FRAC_BITS;
  localparam int PUSH_REACH = RAD + HALF;
  localparam int D_OFF      = RAD - HALF;
  localparam int LO_OFF     = -2 * RAD;
  localparam int HI_OFF     = 2 * HALF;
  localparam int POS_MIN    = -(2 ** (POS_W - 1));
  localparam int POS_MAX    = (2 ** (POS_W - 1)) - 1;

  // Exact reciprocal for floor(pixel / TILE_PX), pixel < 2**PIX_W
  localparam int unsigned TILE_L   = $clog2(TILE_PX);
  localparam int unsigned RECIP_SH = PIX_W + TILE_L;
  localparam int unsigned RECIP_W  = PIX_W + 2;
  localparam int unsigned PROD_W   = PIX_W + RECIP_W;
  localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_SH) + longint'(TILE_PX) - 1) / longint'(TILE_PX);

  // Result buffer
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OCC_W     = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_RESOLVE = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic                    hit;
  } result_t;

endpackage

[src/tgbc_in_if.sv]
// Input channel of the tile grid box collision core: valid/ready plus one item.
// Depends on tgbc_pkg.
interface tgbc_in_if import tgbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [CELL_W-1:0]       cell_col;
  logic [CELL_W-1:0]       cell_row;
  logic                    cell_blocked;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (
    output valid, action, cell_col, cell_row, cell_blocked, pos_x, pos_y,
    input  ready
  );
  modport sink (
    input  valid, action, cell_col, cell_row, cell_blocked, pos_x, pos_y,
    output ready
  );
endinterface

[src/tgbc_out_if.sv]
// Output channel of the tile grid box collision core: valid/ready plus one result.
// Depends on tgbc_pkg.
interface tgbc_out_if import tgbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic                    hit;

  modport source (output valid, new_x, new_y, hit, input ready);
  modport sink (input valid, new_x, new_y, hit, output ready);
endinterface

[src/tile_grid_box_collision_core.sv]
// Tile grid box collision core: tile occupancy map in a single-port memory,
// map writes and square-agent push-out against blocked tiles.
// Depends on tgbc_pkg, tgbc_in_if and tgbc_out_if.
//
// After reset the map memory, 2**(2*ceil(log2 MAP_SIDE_MAX)) entries (4096 at the
// default side of 64), is cleared one entry per cycle with in_i.ready low;
// register writes are taken throughout. A map write item needs a single access to
// the memory port, so writes stream at one per cycle while intake is not stopped.
// A resolve item reads the tile under each of its four corners through that same
// port, one corner per cycle, and the next item enters the memory stage only after
// its last corner read; the push-out along the smaller overlap is applied per
// corner as its read data returns. Each item returns exactly one result (zeros for
// a write), in order, after passing stages A to D and a final register into the
// result buffer. Up to eight results are buffered, and intake stops once eight
// items are in flight, so a stalled output does not stop intake until then.
module tile_grid_box_collision_core import tgbc_pkg::*; #(
  parameter int unsigned MAP_SIDE_MAX = MAP_SIDE_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tgbc_in_if.sink              in_i,
  tgbc_out_if.source           out_o
);

  localparam int unsigned CW     = (MAP_SIDE_MAX > 1) ? $clog2(MAP_SIDE_MAX) : 1;
  localparam int unsigned ADDR_W = 2 * CW;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  localparam logic [1:0] LAST_BEAT = 2'd3;
  localparam logic [1:0] FIRST_BEAT = 2'd0;

  localparam logic signed [WORK_W-1:0] D_OFF_W = WORK_W'(D_OFF);
  localparam logic signed [WORK_W-1:0] MIN_W   = WORK_W'(PUSH_REACH);
  localparam logic signed [WORK_W-1:0] LO_W    = WORK_W'(LO_OFF);
  localparam logic signed [WORK_W-1:0] HI_W    = WORK_W'(HI_OFF);
  localparam logic signed [WORK_W-1:0] SAT_LO  = WORK_W'(POS_MIN);
  localparam logic signed [WORK_W-1:0] SAT_HI  = WORK_W'(POS_MAX);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WORK_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v < SAT_LO) begin
      r = POS_W'(POS_MIN);
    end else if (v > SAT_HI) begin
      r = POS_W'(POS_MAX);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] map_w_q, map_h_q;
  logic [IDX_W-1:0] used_w, used_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= CFG_W'(MAP_RESET_TILES);
      map_h_q <= CFG_W'(MAP_RESET_TILES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        CFG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign used_w = (IDX_W'(map_w_q) > IDX_W'(MAP_SIDE_MAX)) ? IDX_W'(MAP_SIDE_MAX)
                                                          : IDX_W'(map_w_q);
  assign used_h = (IDX_W'(map_h_q) > IDX_W'(MAP_SIDE_MAX)) ? IDX_W'(MAP_SIDE_MAX)
                                                          : IDX_W'(map_h_q);

  // ---------------- clearing pass ----------------
  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------- flow control ----------------
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_free, b_free, c_free, c_last;
  logic b_take, c_take;
  logic in_fire, out_fire;
  logic [OCC_W-1:0] occ_q, occ_d;

  assign b_free  = !b_valid_q || c_free;
  assign a_free  = !a_valid_q || b_free;
  assign b_take  = a_valid_q && b_free;
  assign c_take  = b_valid_q && c_free;
  assign in_i.ready = !clr_q && a_free && (occ_q < OCC_W'(OUT_DEPTH));
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign occ_d    = occ_q + OCC_W'(in_fire) - OCC_W'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // ---------------- stage A: input register ----------------
  action_e                 a_act_q;
  logic [CELL_W-1:0]       a_col_q, a_row_q;
  logic                    a_blk_q;
  logic signed [POS_W-1:0] a_px_q, a_py_q;
  logic signed [POS_W:0]   a_cx  [4];
  logic signed [POS_W:0]   a_pix [4];
  logic [PROD_W-1:0]       a_prod [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (b_take) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_act_q <= action_e'(in_i.action);
      a_col_q <= in_i.cell_col;
      a_row_q <= in_i.cell_row;
      a_blk_q <= in_i.cell_blocked;
      a_px_q  <= in_i.pos_x;
      a_py_q  <= in_i.pos_y;
    end
  end

  // corner coordinates: x, x+side, y, y+side
  always_comb begin
    a_cx[0] = (POS_W+1)'(a_px_q);
    a_cx[1] = (POS_W+1)'(a_px_q) + (POS_W+1)'(SIDE);
    a_cx[2] = (POS_W+1)'(a_py_q);
    a_cx[3] = (POS_W+1)'(a_py_q) + (POS_W+1)'(SIDE);
    for (int i = 0; i < 4; i++) begin
      a_pix[i]  = a_cx[i] >>> FRAC_BITS;
      a_prod[i] = PROD_W'(a_pix[i][PIX_W-1:0]) * PROD_W'(RECIP_M);
    end
  end

  // ---------------- stage B: tile index ----------------
  action_e                 b_act_q;
  logic [CELL_W-1:0]       b_col_q, b_row_q;
  logic                    b_blk_q;
  logic signed [POS_W-1:0] b_px_q, b_py_q;
  logic [PROD_W-1:0]       b_prod_q [4];
  logic                    b_neg_q  [4];
  logic [PROD_W-1:0]       b_idx [4];
  logic [PROD_W-1:0]       b_lim [4];
  logic                    b_in  [4];
  logic [IDX_W-1:0]        b_col_ext, b_row_ext;
  logic                    b_wr_ok;
  logic [ADDR_W-1:0]       b_waddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_take) begin
      b_valid_q <= 1'b1;
    end else if (c_take) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_take) begin
      b_act_q <= a_act_q;
      b_col_q <= a_col_q;
      b_row_q <= a_row_q;
      b_blk_q <= a_blk_q;
      b_px_q  <= a_px_q;
      b_py_q  <= a_py_q;
      for (int i = 0; i < 4; i++) begin
        b_prod_q[i] <= a_prod[i];
        b_neg_q[i]  <= a_cx[i][POS_W];
      end
    end
  end

  always_comb begin
    b_lim[0] = PROD_W'(used_w);
    b_lim[1] = PROD_W'(used_w);
    b_lim[2] = PROD_W'(used_h);
    b_lim[3] = PROD_W'(used_h);
    for (int i = 0; i < 4; i++) begin
      b_idx[i] = b_prod_q[i] >> RECIP_SH;
      b_in[i]  = !b_neg_q[i] && (b_idx[i] < b_lim[i]);
    end
    b_col_ext = IDX_W'(b_col_q);
    b_row_ext = IDX_W'(b_row_q);
    b_wr_ok   = (b_col_ext < IDX_W'(MAP_SIDE_MAX)) && (b_row_ext < IDX_W'(MAP_SIDE_MAX));
    b_waddr   = {b_row_ext[CW-1:0], b_col_ext[CW-1:0]};
  end

  // ---------------- stage C: memory access ----------------
  action_e                  c_act_q;
  logic                     c_blk_q, c_wr_ok_q;
  logic [ADDR_W-1:0]        c_waddr_q;
  logic signed [POS_W-1:0]  c_px_q, c_py_q;
  logic [CW-1:0]            c_col0_q, c_col1_q, c_row0_q, c_row1_q;
  logic                     c_vx0_q, c_vx1_q, c_vy0_q, c_vy1_q;
  logic [1:0]               c_beat_q;
  logic [CW-1:0]            c_col, c_row;
  logic                     c_hitok;
  logic signed [WORK_W-1:0] c_ctx, c_cty;

  assign c_last = c_valid_q && ((c_act_q == ACT_WRITE) || (c_beat_q == LAST_BEAT));
  assign c_free = !c_valid_q || c_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      c_beat_q  <= FIRST_BEAT;
    end else if (c_take) begin
      c_valid_q <= 1'b1;
      c_beat_q  <= FIRST_BEAT;
    end else if (c_valid_q) begin
      c_valid_q <= !c_last;
      c_beat_q  <= c_beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_take) begin
      c_act_q   <= b_act_q;
      c_blk_q   <= b_blk_q;
      c_wr_ok_q <= b_wr_ok;
      c_waddr_q <= b_waddr;
      c_px_q    <= b_px_q;
      c_py_q    <= b_py_q;
      c_col0_q  <= b_idx[0][CW-1:0];
      c_col1_q  <= b_idx[1][CW-1:0];
      c_row0_q  <= b_idx[2][CW-1:0];
      c_row1_q  <= b_idx[3][CW-1:0];
      c_vx0_q   <= b_in[0];
      c_vx1_q   <= b_in[1];
      c_vy0_q   <= b_in[2];
      c_vy1_q   <= b_in[3];
    end
  end

  // corner order: (x,y) (x+s,y) (x,y+s) (x+s,y+s)
  assign c_col   = c_beat_q[0] ? c_col1_q : c_col0_q;
  assign c_row   = c_beat_q[1] ? c_row1_q : c_row0_q;
  assign c_hitok = (c_beat_q[0] ? c_vx1_q : c_vx0_q) && (c_beat_q[1] ? c_vy1_q : c_vy0_q);
  assign c_ctx   = WORK_W'(c_col) * WORK_W'(TILE);
  assign c_cty   = WORK_W'(c_row) * WORK_W'(TILE);

  // ---------------- map memory ----------------
  logic              mem_q [DEPTH];
  logic              mem_we, mem_wd, rd_q;
  logic [ADDR_W-1:0] mem_addr;

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    mem_addr = {c_row, c_col};
    if (clr_q) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_q;
    end else if (c_valid_q && (c_act_q == ACT_WRITE)) begin
      mem_we   = c_wr_ok_q;
      mem_wd   = c_blk_q;
      mem_addr = c_waddr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wd;
    end
    rd_q <= mem_q[mem_addr];
  end

  // ---------------- stage D: push-out ----------------
  logic                     d_valid_q;
  action_e                  d_act_q;
  logic                     d_first_q, d_last_q, d_hitok_q;
  logic signed [WORK_W-1:0] d_ctx_q, d_cty_q, d_px0_q, d_py0_q;
  logic signed [WORK_W-1:0] acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  logic                     acc_hit_q, acc_hit_d;
  logic signed [WORK_W-1:0] bx, by, dx, dy, xd, yd;
  logic                     blocked;
  logic                     fin_valid_q;
  action_e                  fin_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q   <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      d_valid_q   <= c_valid_q && !clr_q;
      fin_valid_q <= d_valid_q && d_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_act_q   <= c_act_q;
    d_first_q <= (c_beat_q == FIRST_BEAT);
    d_last_q  <= c_last;
    d_hitok_q <= c_hitok;
    d_ctx_q   <= c_ctx;
    d_cty_q   <= c_cty;
    d_px0_q   <= WORK_W'(c_px_q);
    d_py0_q   <= WORK_W'(c_py_q);
    fin_act_q <= d_act_q;
    if (d_valid_q && (d_act_q == ACT_RESOLVE)) begin
      acc_x_q   <= acc_x_d;
      acc_y_q   <= acc_y_d;
      acc_hit_q <= acc_hit_d;
    end
  end

  // the pushed coordinate is the tile edge plus a constant, so only the overlaps
  // need the current position
  always_comb begin
    bx      = d_first_q ? d_px0_q : acc_x_q;
    by      = d_first_q ? d_py0_q : acc_y_q;
    dx      = bx + D_OFF_W - d_ctx_q;
    dy      = by + D_OFF_W - d_cty_q;
    xd      = dx[WORK_W-1] ? (MIN_W + dx) : (MIN_W - dx);
    yd      = dy[WORK_W-1] ? (MIN_W + dy) : (MIN_W - dy);
    blocked = d_hitok_q && rd_q;
    acc_x_d = bx;
    acc_y_d = by;
    if (blocked && (xd > 0) && (yd > 0)) begin
      if (xd < yd) begin
        acc_x_d = dx[WORK_W-1] ? (d_ctx_q + LO_W) : (d_ctx_q + HI_W);
      end else begin
        acc_y_d = dy[WORK_W-1] ? (d_cty_q + LO_W) : (d_cty_q + HI_W);
      end
    end
    acc_hit_d = (d_first_q ? 1'b0 : acc_hit_q) || blocked;
  end

  // ---------------- result buffer ----------------
  result_t                fifo_q [OUT_DEPTH];
  result_t                fifo_wd;
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0]       fifo_cnt_q, fifo_cnt_d;

  always_comb begin
    fifo_wd = '0;
    if (fin_act_q == ACT_RESOLVE) begin
      fifo_wd.new_x = sat_pos(acc_x_q);
      fifo_wd.new_y = sat_pos(acc_y_q);
      fifo_wd.hit   = acc_hit_q;
    end
  end

  assign fifo_cnt_d = fifo_cnt_q + OCC_W'(fin_valid_q) - OCC_W'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (fin_valid_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_q) begin
      fifo_q[wr_ptr_q] <= fifo_wd;
    end
  end

  assign out_o.valid = (fifo_cnt_q != '0);
  assign out_o.new_x = fifo_q[rd_ptr_q].new_x;
  assign out_o.new_y = fifo_q[rd_ptr_q].new_y;
  assign out_o.hit   = fifo_q[rd_ptr_q].hit;

  // ---------------- assertions ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(OUT_DEPTH))
    else $error("items in flight exceed result buffer depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> (fifo_cnt_q < OCC_W'(OUT_DEPTH)) || out_fire)
    else $error("result buffer overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= occ_q)
    else $error("more buffered results than transferred items");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !c_valid_q && !in_i.ready)
    else $error("map access during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q && (d_act_q == ACT_RESOLVE) && !d_last_q |=> d_valid_q && !d_first_q)
    else $error("resolve corner reads not contiguous");

endmodule
